### design/tkn_heap_pkg.sv
// ----------------------------------------------------------------------------
// tkn_heap_pkg
// Shared types and constants for the top-k nearest heap core.
// ----------------------------------------------------------------------------
package tkn_heap_pkg;

  localparam int unsigned MaxKDefault   = 64;
  localparam int unsigned IdBitsDefault = 20;
  localparam int unsigned KeyW          = 32;
  localparam int unsigned OutIdW        = 20;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned SlotW         = 6;
  localparam int unsigned SizeW         = 7;
  localparam logic [KeyW-1:0]  EmptyKey    = 32'h7149F2CA;
  localparam logic [SizeW-1:0] SizeReset   = 7'd16;

  typedef enum logic [CmdW-1:0] {
    CmdClear  = 2'd0,
    CmdInsert = 2'd1,
    CmdRead   = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StRoot,
    StDup,
    StSiftL,
    StSiftR,
    StSiftCmp,
    StOut
  } state_e;

endpackage

### design/top_k_nearest_heap_core.sv
// ----------------------------------------------------------------------------
// top_k_nearest_heap_core
// Bounded max-heap keeping the k smallest-distance candidates.
// ----------------------------------------------------------------------------
// Channel | dir | contents
// s_axis  | in  | tdata: command, candidate_id, candidate_key, read_slot
// m_axis  | out | tdata: accepted, slot_key, slot_id, slot_empty, slot_fresh
// cfg     | in  | list_size (7 bits), taken only while idle
//
// Sequence: clear, read and unused command go from idle to the output state
// and back. Insert: a root check, a duplicate scan of the other slots (one
// slot per cycle through the single read port), a left read, a right read and
// a compare per level where the candidate has a child, a write where it settles,
// then the result load and the return to idle. A key not below the root is turned away.
// Reset: the written-since-clear flags drop at once, so unwritten slots read
// as empty and the memory needs no clearing pass. Clear does the same.
// Stalls: the result register holds until m_axis_tready; a finished item
// waits in the output state while an older result is still pending.
// ----------------------------------------------------------------------------
module top_k_nearest_heap_core #(
  parameter int unsigned MAX_K   = tkn_heap_pkg::MaxKDefault,
  parameter int unsigned ID_BITS = tkn_heap_pkg::IdBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [21:2] candidate_id, [53:22] candidate_key,
  // [59:54] read_slot, [63:60] zero
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [32:1] slot_key, [52:33] slot_id, [53] slot_empty,
  // [54] slot_fresh, [55] zero
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CW = $clog2(MAX_K + 1);   // holds k
  localparam int unsigned IW = AW + 2;              // child index
  localparam int unsigned KW = tkn_heap_pkg::KeyW;

  typedef struct packed {
    logic               empty;
    logic               fresh;
    logic [ID_BITS-1:0] id;
    logic [KW-1:0]      key;
  } entry_t;

  tkn_heap_pkg::state_e state_q, state_d;

  // slot memory; valid_q marks slots written since the last clear
  entry_t           mem_q [MAX_K];
  logic [MAX_K-1:0] valid_q, valid_d;
  entry_t           rd_data_q;
  logic             rd_vld_q;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;
  entry_t           rd_ent;        // read view, unwritten slot shows cleared contents

  logic [tkn_heap_pkg::SizeW-1:0] size_q;
  logic [CW-1:0] k_eff;
  logic [AW-1:0] cnt_q, cnt_d;     // slot whose data is back in the scan
  logic [AW-1:0] node_q, node_d;   // position of the candidate while sifting
  entry_t        left_q, left_d;   // left child seen in the current level
  logic          acc_q, acc_d;

  tkn_heap_pkg::cmd_e             cmd_q;
  logic [ID_BITS-1:0]             cid_q;
  logic [KW-1:0]                  ckey_q;
  logic [tkn_heap_pkg::SlotW-1:0] slot_q;
  logic [55:0]                    res_q, res_d;
  logic                           ovalid_q, ovalid_d;

  tkn_heap_pkg::cmd_e in_cmd;
  logic          accept_in;
  logic          cfg_we;
  logic          out_load;
  entry_t        cand;
  logic [IW-1:0] left_idx;
  logic [IW-1:0] right_idx;
  logic          left_ok;
  logic          right_ok;
  logic          dup_hit;
  logic          root_pass;
  logic          scan_last;
  logic          go_left;
  logic          go_right;
  logic [KW-1:0] big_key;

  assign in_cmd        = tkn_heap_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign s_axis_tready = (state_q == tkn_heap_pkg::StIdle);
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = (state_q == tkn_heap_pkg::StIdle);
  assign cfg_we        = cfg_valid_i && cfg_ready_o;
  assign out_load      = (state_q == tkn_heap_pkg::StOut) && (!ovalid_q || m_axis_tready);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = res_q;

  // list_size 0 acts as 1, above MAX_K as MAX_K
  always_comb begin
    if (size_q == '0) begin
      k_eff = CW'(1);
    end else if (32'(size_q) > MAX_K) begin
      k_eff = CW'(MAX_K);
    end else begin
      k_eff = CW'(size_q);
    end
  end

  always_comb begin
    if (rd_vld_q) begin
      rd_ent = rd_data_q;
    end else begin
      rd_ent.empty = 1'b1;
      rd_ent.fresh = 1'b1;
      rd_ent.id    = '0;
      rd_ent.key   = tkn_heap_pkg::EmptyKey;
    end
  end

  always_comb begin
    cand.empty = 1'b0;
    cand.fresh = 1'b1;
    cand.id    = cid_q;
    cand.key   = ckey_q;
  end

  assign left_idx  = {1'b0, node_q, 1'b1};
  assign right_idx = left_idx + IW'(1);
  assign left_ok   = left_idx < IW'(k_eff);
  assign right_ok  = right_idx < IW'(k_eff);
  assign dup_hit   = !rd_ent.empty && (rd_ent.id == cid_q);
  assign root_pass = (ckey_q < rd_ent.key) && !dup_hit;
  assign scan_last = (CW'(cnt_q) + CW'(1)) == k_eff;

  // larger child wins, left first on a tie, only if strictly above the candidate
  assign go_left  = left_q.key > ckey_q;
  assign big_key  = go_left ? left_q.key : ckey_q;
  assign go_right = right_ok && (rd_ent.key > big_key);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tkn_heap_pkg::StIdle: begin
        if (accept_in) begin
          case (in_cmd)
            tkn_heap_pkg::CmdInsert: state_d = tkn_heap_pkg::StRoot;
            default:                 state_d = tkn_heap_pkg::StOut;
          endcase
        end
      end
      tkn_heap_pkg::StRoot: begin
        if (!root_pass)             state_d = tkn_heap_pkg::StOut;
        else if (k_eff == CW'(1))   state_d = tkn_heap_pkg::StSiftL;
        else                        state_d = tkn_heap_pkg::StDup;
      end
      tkn_heap_pkg::StDup: begin
        if (dup_hit)        state_d = tkn_heap_pkg::StOut;
        else if (scan_last) state_d = tkn_heap_pkg::StSiftL;
      end
      tkn_heap_pkg::StSiftL: begin
        state_d = left_ok ? tkn_heap_pkg::StSiftR : tkn_heap_pkg::StOut;
      end
      tkn_heap_pkg::StSiftR:   state_d = tkn_heap_pkg::StSiftCmp;
      tkn_heap_pkg::StSiftCmp: begin
        state_d = (go_left || go_right) ? tkn_heap_pkg::StSiftL : tkn_heap_pkg::StOut;
      end
      tkn_heap_pkg::StOut: begin
        if (out_load) state_d = tkn_heap_pkg::StIdle;
      end
      default: state_d = tkn_heap_pkg::StIdle;
    endcase
  end

  // memory control and sift datapath
  always_comb begin
    cnt_d   = cnt_q;
    node_d  = node_q;
    left_d  = left_q;
    acc_d   = acc_q;
    valid_d = valid_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = cand;
    case (state_q)
      tkn_heap_pkg::StIdle: begin
        if (accept_in) begin
          acc_d  = 1'b0;
          node_d = '0;
          rd_en  = 1'b1;
          // insert looks at the root first, read at the requested slot
          if (in_cmd == tkn_heap_pkg::CmdInsert) rd_addr = '0;
          else                                   rd_addr = AW'(s_axis_tdata[59:54]);
          if (in_cmd == tkn_heap_pkg::CmdClear) valid_d = '0;
        end
      end
      tkn_heap_pkg::StRoot: begin
        // root is slot 0 of the scan; carry on from slot 1
        if (root_pass && k_eff != CW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(1);
          cnt_d   = AW'(1);
        end
      end
      tkn_heap_pkg::StDup: begin
        if (!dup_hit && !scan_last) begin
          rd_en   = 1'b1;
          rd_addr = cnt_q + AW'(1);
          cnt_d   = cnt_q + AW'(1);
        end
      end
      tkn_heap_pkg::StSiftL: begin
        if (left_ok) begin
          rd_en   = 1'b1;
          rd_addr = AW'(left_idx);
        end else begin
          // leaf: candidate settles here
          wr_en   = 1'b1;
          wr_addr = node_q;
          wr_data = cand;
          acc_d   = 1'b1;
        end
      end
      tkn_heap_pkg::StSiftR: begin
        left_d = rd_ent;
        if (right_ok) begin
          rd_en   = 1'b1;
          rd_addr = AW'(right_idx);
        end
      end
      tkn_heap_pkg::StSiftCmp: begin
        wr_en   = 1'b1;
        wr_addr = node_q;
        if (go_right) begin
          wr_data = rd_ent;
          node_d  = AW'(right_idx);
        end else if (go_left) begin
          wr_data = left_q;
          node_d  = AW'(left_idx);
        end else begin
          wr_data = cand;
          acc_d   = 1'b1;
        end
      end
      default: ;
    endcase
    if (wr_en) valid_d[wr_addr] = 1'b1;
  end

  // result and output register control
  always_comb begin
    res_d = '0;
    case (cmd_q)
      tkn_heap_pkg::CmdInsert: res_d[0] = acc_q;
      tkn_heap_pkg::CmdRead: begin
        if (32'(slot_q) < MAX_K) begin
          res_d[54:1] = {rd_ent.fresh, rd_ent.empty,
                         tkn_heap_pkg::OutIdW'(rd_ent.id), rd_ent.key};
        end else begin
          res_d[53] = 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load)           ovalid_d = 1'b1;
    else if (m_axis_tready) ovalid_d = 1'b0;
    else                    ovalid_d = ovalid_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tkn_heap_pkg::StIdle;
      valid_q  <= '0;
      size_q   <= tkn_heap_pkg::SizeReset;
      ovalid_q <= 1'b0;
      res_q    <= '0;
      cnt_q    <= '0;
      node_q   <= '0;
      acc_q    <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
      node_q   <= node_d;
      acc_q    <= acc_d;
      if (out_load) res_q <= res_d;
      if (rd_en) rd_vld_q <= valid_q[rd_addr];
      if (cfg_we) size_q <= cfg_data_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cmd_q  <= in_cmd;
      cid_q  <= ID_BITS'(s_axis_tdata[21:2]);
      ckey_q <= s_axis_tdata[53:22];
      slot_q <= s_axis_tdata[59:54];
    end
    left_q <= left_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready) |=> (ovalid_q && $stable(res_q)))
    else $error("result dropped or changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !rd_en)
    else $error("read and write in one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tkn_heap_pkg::StSiftCmp) && (go_left || go_right)) |-> (node_d > node_q))
    else $error("sift moved upwards");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tkn_heap_pkg::StDup) |-> (CW'(cnt_q) < k_eff))
    else $error("scan past the list");

endmodule
